@@ src/lztgp_pkg.sv @@
// Package for the LZ token group packer.
// Holds buffer sizes, format constants and the structs passed between submodules.
// No dependencies.
package lztgp_pkg;

  localparam int unsigned CHUNKS_PER_GROUP = 8;
  localparam int unsigned CHK_W            = $clog2(CHUNKS_PER_GROUP);
  localparam int unsigned BUF_DEPTH        = 24;
  localparam int unsigned ADDR_W           = $clog2(BUF_DEPTH);
  localparam int unsigned CNT_W            = $clog2(BUF_DEPTH + 1);
  localparam int unsigned TOP_BIT          = 7;
  localparam logic [7:0]  LONG_LEN_BASE    = 8'h12;
  localparam logic [7:0]  EMPTY_MARK       = 8'hff;

  typedef enum logic {
    OP_TOKEN = 1'b0,
    OP_FLUSH = 1'b1
  } opcode_e;

  // Up to three byte writes per token, at addr, addr+1 and addr+2.
  typedef struct packed {
    logic [2:0]      en;
    logic [ADDR_W-1:0] addr;
    logic [2:0][7:0] data;
  } bank_wr_t;

  // A closed group handed from the packer to the emitter.
  typedef struct packed {
    logic             valid;
    logic             bank;
    logic [7:0]       header;
    logic [CNT_W-1:0] count;
    logic             err;
  } grp_desc_t;

endpackage

@@ src/lztgp_bank.sv @@
// Chunk byte buffer for one group: 24 bytes, three write lanes, one read.
// Depends on lztgp_pkg.
module lztgp_bank (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  lztgp_pkg::bank_wr_t            wr_i,
  input  logic [lztgp_pkg::ADDR_W-1:0]   rd_addr_i,
  output logic [7:0]                     rd_data_o
);

  logic [7:0] mem_q [lztgp_pkg::BUF_DEPTH];

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      if (we_i && wr_i.en[k]) begin
        mem_q[lztgp_pkg::ADDR_W'(wr_i.addr + lztgp_pkg::ADDR_W'(k))] <= wr_i.data[k];
      end
    end
  end

  // Out-of-range addresses occur only while the header is selected.
  assign rd_data_o = (rd_addr_i < lztgp_pkg::ADDR_W'(lztgp_pkg::BUF_DEPTH)) ?
                     mem_q[rd_addr_i] : 8'h00;

endmodule

@@ src/lztgp_pack.sv @@
// Token encoder: turns one token into chunk bytes, keeps the group counters
// and closes groups. Depends on lztgp_pkg.
module lztgp_pack (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  opcode_i,
  input  logic [15:0]           dist_req_i,
  input  logic [7:0]            lc_i,
  input  logic [1:0]            busy_i,
  output lztgp_pkg::bank_wr_t   wr_o,
  output logic                  wr_bank_o,
  output lztgp_pkg::grp_desc_t  desc_o
);

  logic                          wb_q;
  logic [lztgp_pkg::CNT_W-1:0]   byte_cnt_q, byte_cnt_d;
  logic [lztgp_pkg::CHK_W-1:0]   chunk_q;
  logic [7:0]                    hdr_q, hdr_d;
  logic                          err_q, err_d;

  logic        accept, is_flush, is_lit, is_short, far, group_full, close;
  logic [15:0] dist_m1;
  logic [8:0]  len, len_m2, len_long;
  logic [7:0]  lit_bit;
  logic [1:0]  nbytes;
  logic [2:0]  en;
  logic [2:0][7:0] data;

  assign in_ready_o = !busy_i[wb_q];
  assign accept     = in_valid_i && in_ready_o;
  assign is_flush   = opcode_i == lztgp_pkg::OP_FLUSH;
  assign is_lit     = dist_req_i == 16'd0;
  assign dist_m1    = dist_req_i - 16'd1;
  assign far        = |dist_m1[15:12];
  assign len        = {1'b0, lc_i} + 9'd3;
  assign len_m2     = len - 9'd2;
  assign len_long   = len - {1'b0, lztgp_pkg::LONG_LEN_BASE};
  assign is_short   = len < {1'b0, lztgp_pkg::LONG_LEN_BASE};
  assign lit_bit    = 8'd1 << (lztgp_pkg::CHK_W'(lztgp_pkg::TOP_BIT) - chunk_q);
  assign group_full = chunk_q == lztgp_pkg::CHK_W'(lztgp_pkg::CHUNKS_PER_GROUP - 1);
  assign close      = accept && (is_flush || group_full);

  always_comb begin
    data = '0;
    if (is_lit) begin
      en      = 3'b001;
      nbytes  = 2'd1;
      data[0] = lc_i;
    end else if (is_short) begin
      en      = 3'b011;
      nbytes  = 2'd2;
      data[0] = {len_m2[3:0], dist_m1[11:8]};
      data[1] = dist_m1[7:0];
    end else begin
      en      = 3'b111;
      nbytes  = 2'd3;
      data[0] = {4'h0, dist_m1[11:8]};
      data[1] = dist_m1[7:0];
      data[2] = len_long[7:0];
    end
  end

  assign hdr_d      = is_lit ? (hdr_q | lit_bit) : hdr_q;
  assign err_d      = err_q | (!is_lit && far);
  assign byte_cnt_d = byte_cnt_q + lztgp_pkg::CNT_W'(nbytes);

  assign wr_o.en    = (accept && !is_flush) ? en : 3'b000;
  assign wr_o.addr  = lztgp_pkg::ADDR_W'(byte_cnt_q);
  assign wr_o.data  = data;
  assign wr_bank_o  = wb_q;

  always_comb begin
    desc_o.valid = close;
    desc_o.bank  = wb_q;
    if (is_flush) begin
      desc_o.header = (chunk_q == '0) ? lztgp_pkg::EMPTY_MARK : hdr_q;
      desc_o.count  = byte_cnt_q;
      desc_o.err    = err_q;
    end else begin
      desc_o.header = hdr_d;
      desc_o.count  = byte_cnt_d;
      desc_o.err    = err_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wb_q       <= 1'b0;
      byte_cnt_q <= '0;
      chunk_q    <= '0;
      hdr_q      <= 8'h00;
      err_q      <= 1'b0;
    end else if (accept) begin
      if (close) begin
        wb_q       <= !wb_q;
        byte_cnt_q <= '0;
        chunk_q    <= '0;
        hdr_q      <= 8'h00;
        err_q      <= 1'b0;
      end else begin
        byte_cnt_q <= byte_cnt_d;
        chunk_q    <= chunk_q + lztgp_pkg::CHK_W'(1);
        hdr_q      <= hdr_d;
        err_q      <= err_d;
      end
    end
  end

endmodule

@@ src/lztgp_emit.sv @@
// Group emitter: owns the closed groups per bank and streams header and
// chunk bytes through the output register. Depends on lztgp_pkg.
module lztgp_emit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  lztgp_pkg::grp_desc_t           desc_i,
  output logic [lztgp_pkg::ADDR_W-1:0]   rd_addr_o,
  input  logic [1:0][7:0]                rd_data_i,
  output logic [1:0]                     busy_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [7:0]                     out_byte_o,
  output logic                           last_o,
  output logic                           bad_distance_o
);

  logic [1:0]                  busy_q, busy_d;
  logic                        rb_q;
  logic [lztgp_pkg::CNT_W-1:0] idx_q;
  logic [7:0]                  hdr_q [2];
  logic [lztgp_pkg::CNT_W-1:0] cnt_q [2];
  logic [1:0]                  err_q;
  logic                        out_valid_q;
  logic [7:0]                  out_byte_q;
  logic                        last_q, bad_q;
  logic                        load, is_last;

  assign rd_addr_o = lztgp_pkg::ADDR_W'(idx_q - lztgp_pkg::CNT_W'(1));
  assign load      = busy_q[rb_q] && (!out_valid_q || out_ready_i);
  assign is_last   = idx_q == cnt_q[rb_q];

  always_comb begin
    busy_d = busy_q;
    if (load && is_last) begin
      busy_d[rb_q] = 1'b0;
    end
    if (desc_i.valid) begin
      busy_d[desc_i.bank] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 2'b00;
      rb_q        <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      if (load) begin
        out_valid_q <= 1'b1;
        if (is_last) begin
          rb_q  <= !rb_q;
          idx_q <= '0;
        end else begin
          idx_q <= idx_q + lztgp_pkg::CNT_W'(1);
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (desc_i.valid) begin
      hdr_q[desc_i.bank] <= desc_i.header;
      cnt_q[desc_i.bank] <= desc_i.count;
      err_q[desc_i.bank] <= desc_i.err;
    end
    if (load) begin
      out_byte_q <= (idx_q == '0) ? hdr_q[rb_q] : rd_data_i[rb_q];
      last_q     <= is_last;
      bad_q      <= err_q[rb_q];
    end
  end

  assign busy_o         = busy_q;
  assign out_valid_o    = out_valid_q;
  assign out_byte_o     = out_byte_q;
  assign last_o         = last_q;
  assign bad_distance_o = bad_q;

endmodule

@@ src/lz_token_group_packer.sv @@
// LZ token group packer, top level. The header byte of a group reaches the output
// via the bank's busy flag and then the output register once the group is closed.
// Throughput: one token per cycle while a free bank exists; output one byte per
// cycle while out_ready_i is high, set by the output register; a group of n chunk
// bytes leaves as n+1 bytes. Sustained token rate is bound by the one-byte output.
// Reset (rst_ni low, asynchronous) clears counters, bank ownership and out_valid_o.
module lz_token_group_packer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        opcode_i,
  input  logic [15:0] dist_req_i,
  input  logic [7:0]  lc_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        last_o,
  output logic        bad_distance_o
);

  // Two chunk banks work in ping-pong: the packer fills one while the emitter
  // drains the other. A bank belongs to the emitter from the transaction that
  // closes its group until its final byte is loaded into the output register.
  lztgp_pkg::bank_wr_t             wr;
  lztgp_pkg::grp_desc_t            desc;
  logic                            wr_bank;
  logic [1:0]                      busy;
  logic [lztgp_pkg::ADDR_W-1:0]    rd_addr;
  logic [1:0][7:0]                 rd_data;

  // Encode the token, advance the group counters, and close the group on the
  // eighth chunk or on a flush. Stall input while the fill bank is still owned.
  lztgp_pack u_pack (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .opcode_i   (opcode_i),
    .dist_req_i (dist_req_i),
    .lc_i       (lc_i),
    .busy_i     (busy),
    .wr_o       (wr),
    .wr_bank_o  (wr_bank),
    .desc_o     (desc)
  );

  // Hold the chunk bytes; both banks share the emitter's read address.
  for (genvar b = 0; b < 2; b++) begin : g_bank
    lztgp_bank u_bank (
      .clk_i     (clk_i),
      .we_i      (wr_bank == 1'(b)),
      .wr_i      (wr),
      .rd_addr_i (rd_addr),
      .rd_data_o (rd_data[b])
    );
  end

  // Stream header then chunk bytes, oldest group first; mark the final byte.
  lztgp_emit u_emit (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .desc_i         (desc),
    .rd_addr_o      (rd_addr),
    .rd_data_i      (rd_data),
    .busy_o         (busy),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_byte_o     (out_byte_o),
    .last_o         (last_o),
    .bad_distance_o (bad_distance_o)
  );

endmodule

@@ src/lztgp_checker.sv @@
// Port-level checks for the LZ token group packer, bound to the top level.
// Depends on lztgp_pkg and lz_token_group_packer.
module lztgp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        opcode_i,
  input logic [15:0] dist_req_i,
  input logic [7:0]  lc_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [7:0]  out_byte_o,
  input logic        last_o,
  input logic        bad_distance_o
);

  // No output transaction is offered while reset is held.
  assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("out_valid_o high during reset");

  // A stalled output transaction holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o) && $stable(last_o))
    else $error("stalled output changed");

  // Bytes of one group stream without gaps and carry one error flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_o |=>
      out_valid_o && (bad_distance_o == $past(bad_distance_o)))
    else $error("group stream broken or error flag changed");

  // A flush accepted with an idle output produces a registered output byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (opcode_i == lztgp_pkg::OP_FLUSH) && !out_valid_o
      |-> ##2 out_valid_o)
    else $error("flush produced no output");

endmodule

bind lz_token_group_packer lztgp_checker u_lztgp_checker (.*);
